// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the stack block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: sv/msa_pkg.sv
// Types, codes and defaults for the shared-array multi-stack block.
// No dependencies; imported by the top level.
package msa_pkg;

  localparam int STACK_COUNT_DEF = 4;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int VALUE_W = 32;
  localparam int SEL_W   = 3;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_STACK = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                        opcode;
    logic [SEL_W-1:0]           stack_number;
    logic signed [VALUE_W-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    status_e                    status;
    logic                       now_full;
    logic                       now_empty;
  } out_item_t;

endpackage

// File: sv/msa_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies; used for the shared stack storage.
module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/multi_stack_shared_array.sv
// Top level: several fixed-depth LIFO stacks carved out of one shared RAM.
// Depends on msa_pkg (types, codes, defaults), msa_ram and assert_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// One item is accepted per cycle while in_stall_o is low. At the accept edge the
// RAM read and the result stage are captured; the output register takes the
// result when it is not held by out_stall_i. Fill counts live in flip-flops and
// update at the accept edge, so the next item sees them at once; a push followed
// by a pop of the same entry reads the RAM after the write, which needs no bypass.
// Reset clears the fill counts and all valid flags; the RAM is not cleared.
// in_stall_o rises only when the result stage is full and the output register
// is held by out_stall_i.
`include "assert_macros.svh"

module multi_stack_shared_array
  import msa_pkg::*;
#(
  parameter int STACK_COUNT = STACK_COUNT_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int ENTRIES = STACK_COUNT * STACK_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W   = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W   = ADDR_W + CNT_W;

  // Fill counts, one per stack.
  logic [CNT_W-1:0] cnt_q [STACK_COUNT];

  // Decode of the item at the input.
  logic             in_accept;
  logic             sn_ok;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_new;
  logic [CNT_W-1:0] offset;
  logic [SUM_W-1:0] addr_full;
  logic [ADDR_W-1:0] addr;
  logic             do_wr;
  logic             do_rd;
  status_e          a_status;
  logic             a_full;
  logic             a_empty;
  logic [63:0]      push_wide;

  // Result stage: waits for RAM read data.
  logic    b_valid_q, b_valid_d;
  logic    b_rd_q;
  status_e b_status_q;
  logic    b_full_q;
  logic    b_empty_q;
  logic    b_advance;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t out_item_d;

  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [63:0]           rd_wide;

  // Result stage moves on unless the output register is held.
  assign b_advance  = b_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = b_valid_q && out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    sn_ok    = (in_item_i.stack_number != '0) &&
               (int'(in_item_i.stack_number) <= STACK_COUNT);
    idx      = IDX_W'(in_item_i.stack_number - SEL_W'(1));
    cnt_cur  = sn_ok ? cnt_q[idx] : '0;
    cnt_new  = cnt_cur;
    do_wr    = 1'b0;
    do_rd    = 1'b0;
    a_status = ST_OK;
    case (in_item_i.opcode)
      OP_PUSH: begin
        if (cnt_cur == CNT_W'(STACK_DEPTH)) begin
          a_status = ST_FULL;
        end else begin
          do_wr   = 1'b1;
          cnt_new = cnt_cur + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (cnt_cur == '0) begin
          a_status = ST_EMPTY;
        end else begin
          do_rd = 1'b1;
          if (in_item_i.opcode == OP_POP) begin
            cnt_new = cnt_cur - CNT_W'(1);
          end
        end
      end
      default: begin
        // status query: leave everything as it is
      end
    endcase
    a_full  = (cnt_new == CNT_W'(STACK_DEPTH));
    a_empty = (cnt_new == '0);
    // Unknown stack: drop the operation and clear the flags.
    if (!sn_ok) begin
      a_status = ST_NO_STACK;
      do_wr    = 1'b0;
      do_rd    = 1'b0;
      cnt_new  = cnt_cur;
      a_full   = 1'b0;
      a_empty  = 1'b0;
    end
    // Top of stack is at count-1; a push lands at count.
    offset    = do_wr ? cnt_cur : cnt_cur - CNT_W'(1);
    addr_full = SUM_W'(idx) * SUM_W'(STACK_DEPTH) + SUM_W'(offset);
    addr      = addr_full[ADDR_W-1:0];
    push_wide = {32'b0, in_item_i.push_value};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (in_accept && sn_ok) begin
      cnt_q[idx] <= cnt_new;
    end
  end

  msa_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_accept && do_wr),
    .re_i    (in_accept && do_rd),
    .addr_i  (addr),
    .wdata_i (push_wide[DATA_WIDTH-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_accept) begin
      b_valid_d = 1'b1;
    end else if (b_advance) begin
      b_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_rd_q     <= do_rd;
      b_status_q <= a_status;
      b_full_q   <= a_full;
      b_empty_q  <= a_empty;
    end
  end

  // Sign-extend the stored entry, then keep the low 32 bits.
  always_comb begin
    rd_wide                 = 64'($signed(ram_rdata));
    out_item_d.read_value   = b_rd_q ? rd_wide[VALUE_W-1:0] : '0;
    out_item_d.status       = b_status_q;
    out_item_d.now_full     = b_full_q;
    out_item_d.now_empty    = b_empty_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_advance) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_CLK(a_rd_only_ok, clk_i, rst_ni, (b_valid_q && b_rd_q) |-> (b_status_q == ST_OK), "read issued for a failed operation")
  `ASSERT_NEVER(a_full_and_empty, clk_i, rst_ni, b_valid_q && b_full_q && b_empty_q, "stack flagged full and empty at once")
  `ASSERT_CLK(a_no_stack_flags, clk_i, rst_ni, (out_valid_q && out_item_q.status == ST_NO_STACK) |-> (!out_item_q.now_full && !out_item_q.now_empty && out_item_q.read_value == '0), "unknown stack result not cleared")
  `ASSERT_CLK(a_hold_interlock, clk_i, rst_ni, (b_valid_q && !b_advance) |-> in_stall_o, "input open while result stage is held")

endmodule
